// ===== hw/rtl/sac_pkg.sv =====
// shared types, codes and helpers for the set associative cache hit/miss block
// no dependencies; imported by the top level and its checker
package sac_pkg;

    localparam int ADDR_FIELD_W = 48;
    localparam int CFG_DATA_W   = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int COUNT_W      = 32;

    typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [ADDR_FIELD_W-1:0] addr_t;
    typedef logic [COUNT_W-1:0]      count_t;

    // configuration register indexes
    localparam cfg_index_t CFG_SET_BITS    = 2'd0;
    localparam cfg_index_t CFG_OFFSET_BITS = 2'd1;
    localparam cfg_index_t CFG_WAY_COUNT   = 2'd2;
    localparam cfg_index_t CFG_POLICY      = 2'd3;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // replacement policies
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // per access outcome flags
    typedef struct packed {
        logic hit;
        logic memory_read;
        logic memory_write;
    } result_flags_t;

    // saturating increment
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

endpackage

// ===== hw/rtl/sac_ram.sv =====
// simple dual port memory: one write port, one registered read port
// no dependencies; used for the tag store and the per set metadata rows
module sac_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sac_meta_store.sv =====
// per set metadata rows (way valid bits, lru ages, fifo pointer)
// depends on sac_ram; a row never written since reset reads as all zero
module sac_meta_store #(
    parameter int SETS   = 256,
    parameter int ROW_W  = 35,
    parameter int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [SETS-1:0]  row_valid_reg;
    logic [SETS-1:0]  row_valid_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [ROW_W-1:0] ram_q;

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_valid_reg;
        if (rd_en)
        begin
            rd_valid_next = row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

// ===== hw/rtl/set_assoc_cache_hit_miss.sv =====
// set associative cache hit/miss tracker with fifo or lru replacement and write-through
// depends on sac_pkg, sac_ram and sac_meta_store
//
// usage
//   input channel (in_valid/in_ready, kind, address): one transaction per access
//   output channel (out_valid/out_ready): hit, memory_read, memory_write and the
//   four saturating running totals as they stand after that access
//   config port (cfg_write, cfg_index, cfg_data): written while the block is idle
// sequence
//   an accepted access reads the metadata row of its set, then for each way compared
//   reads the tag memory and compares, and ends in the update state, which writes the
//   row, the tag on a miss and the result; 1 to way_count ways are compared (the scan
//   stops at the first hit), one at a time by the single tag comparator, which sees
//   them through the registered tag memory read
// reset
//   valid state lives in per set row flags cleared at once, so no clearing pass;
//   counters go to zero, registers to set_bits 0, offset_bits 0, way_count 1, fifo
// stalls
//   one result register sits on the output; a new access is accepted while a result
//   waits, but it holds in its update cycle until the pending result is taken
module set_assoc_cache_hit_miss #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_write,
    input  sac_pkg::cfg_index_t cfg_index,
    input  sac_pkg::cfg_data_t  cfg_data,
    // access channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  sac_pkg::addr_t      address,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic                memory_read,
    output logic                memory_write,
    output sac_pkg::count_t     read_total,
    output sac_pkg::count_t     write_total,
    output sac_pkg::count_t     hit_total,
    output sac_pkg::count_t     miss_total
);

    import sac_pkg::*;

    // geometry
    localparam int AW        = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX    = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int AGE_W     = WAY_W;
    localparam int ROW_W     = MAX_WAYS + MAX_WAYS * AGE_W + WAY_W;
    localparam int TAG_DEPTH = MAX_SETS * MAX_WAYS;
    localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
    localparam int HI_W      = 5;

    localparam logic [AGE_W-1:0] AGE_CAP   = AGE_W'(MAX_WAYS - 1);
    localparam logic [AGE_W:0]   AGE_FRESH = (AGE_W + 1)'(MAX_WAYS);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_META = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_TCMP = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration registers
    logic [CFG_DATA_W-1:0] set_bits_reg, set_bits_next;
    logic [CFG_DATA_W-1:0] offset_bits_reg, offset_bits_next;
    logic [CFG_DATA_W-1:0] way_count_reg, way_count_next;
    logic                  policy_reg, policy_next;

    // sequencer and access context
    logic [2:0]        state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [AW-1:0]     tag_reg, tag_next;
    logic [WCNT_W-1:0] ways_reg, ways_next;
    logic [WAY_W-1:0]  way_reg, way_next;

    // metadata row of the current set
    logic [MAX_WAYS-1:0] valid_reg, valid_next;
    logic [AGE_W-1:0]    age_reg [MAX_WAYS];
    logic [AGE_W-1:0]    age_next [MAX_WAYS];
    logic [WAY_W-1:0]    fifo_reg, fifo_next;

    // scan results
    logic             hit_found_reg, hit_found_next;
    logic [WAY_W-1:0] hit_way_reg, hit_way_next;
    logic             free_found_reg, free_found_next;
    logic [WAY_W-1:0] free_way_reg, free_way_next;
    logic [AGE_W-1:0] best_age_reg, best_age_next;
    logic [WAY_W-1:0] best_way_reg, best_way_next;

    // results and totals
    result_flags_t flags_reg, flags_next;
    logic          out_valid_reg, out_valid_next;
    count_t        read_cnt_reg, read_cnt_next;
    count_t        write_cnt_reg, write_cnt_next;
    count_t        hit_cnt_reg, hit_cnt_next;
    count_t        miss_cnt_reg, miss_cnt_next;

    // address split at acceptance
    logic [CFG_DATA_W-1:0] eff_sb;
    logic [HI_W-1:0]       tag_shift;
    logic [AW-1:0]         addr_eff;
    logic [AW-1:0]         set_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [WCNT_W-1:0]     eff_ways;

    // memory ports
    logic [TAG_AW-1:0] tag_base;
    logic              tag_rd_en;
    logic [TAG_AW-1:0] tag_rd_addr;
    logic [AW-1:0]     tag_rd_data;
    logic              tag_wr_en;
    logic [TAG_AW-1:0] tag_wr_addr;
    logic              meta_rd_en;
    logic [ROW_W-1:0]  meta_rd_data;
    logic              meta_wr_en;
    logic [ROW_W-1:0]  meta_wr_data;

    // shared compare unit and update terms
    logic             cur_valid;
    logic [AGE_W-1:0] cur_age;
    logic             tag_match;
    logic             last_way;
    logic [WAY_W-1:0] fifo_victim;
    logic [WAY_W-1:0] victim;
    logic             use_fifo;
    logic [AGE_W:0]   mine;
    logic [AGE_W-1:0] upd_age [MAX_WAYS];
    logic             done_go;
    logic             in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign done_go   = !out_valid_reg || out_ready;

    // address split: set bits are clamped to what MAX_SETS holds
    always_comb
    begin
        eff_sb      = (set_bits_reg > CFG_DATA_W'(SB_MAX)) ? CFG_DATA_W'(SB_MAX)
                                                           : set_bits_reg;
        tag_shift   = HI_W'(offset_bits_reg) + HI_W'(eff_sb);
        addr_eff    = address[AW-1:0];
        set_shifted = addr_eff >> offset_bits_reg;
        set_mask    = ~({SET_W{1'b1}} << eff_sb);
        if (way_count_reg == '0)
        begin
            eff_ways = WCNT_W'(1);
        end
        else if (HI_W'(way_count_reg) > HI_W'(MAX_WAYS))
        begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            eff_ways = WCNT_W'(way_count_reg);
        end
    end

    // one tag comparator, one way per pass
    assign cur_valid = valid_reg[way_reg];
    assign cur_age   = age_reg[way_reg];
    assign tag_match = cur_valid && (tag_rd_data == tag_reg);
    assign last_way  = ((WCNT_W'(way_reg) + WCNT_W'(1)) == ways_reg);

    // victim choice and age update for the final cycle
    always_comb
    begin
        fifo_victim = (WCNT_W'(fifo_reg) >= ways_reg) ? '0 : fifo_reg;
        use_fifo    = !hit_found_reg && !free_found_reg && (policy_reg == POLICY_FIFO);
        if (hit_found_reg)
        begin
            victim = hit_way_reg;
        end
        else if (free_found_reg)
        begin
            victim = free_way_reg;
        end
        else if (policy_reg == POLICY_FIFO)
        begin
            victim = fifo_victim;
        end
        else
        begin
            victim = best_way_reg;
        end
        // a freshly filled way counts as older than everything
        mine = hit_found_reg ? {1'b0, age_reg[victim]} : AGE_FRESH;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            upd_age[v] = age_reg[v];
            if (WAY_W'(v) == victim)
            begin
                upd_age[v] = '0;
            end
            else if ((WCNT_W'(v) < ways_reg) && valid_reg[v]
                     && ({1'b0, age_reg[v]} < mine) && (age_reg[v] < AGE_CAP))
            begin
                upd_age[v] = age_reg[v] + AGE_W'(1);
            end
        end
    end

    // metadata row layout: {fifo pointer, ages, valid bits}
    always_comb
    begin
        meta_wr_data                                   = '0;
        meta_wr_data[MAX_WAYS-1:0]                     = valid_reg;
        meta_wr_data[victim]                           = 1'b1;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            meta_wr_data[MAX_WAYS + v * AGE_W +: AGE_W] = upd_age[v];
        end
        meta_wr_data[ROW_W-1 -: WAY_W] = fifo_reg;
        if (use_fifo)
        begin
            meta_wr_data[ROW_W-1 -: WAY_W] =
                ((WCNT_W'(fifo_victim) + WCNT_W'(1)) >= ways_reg) ? '0
                                                                  : fifo_victim + WAY_W'(1);
        end
    end

    assign tag_base    = TAG_AW'(set_reg) * TAG_AW'(MAX_WAYS);
    assign tag_rd_en   = (state_reg == S_TRD);
    assign tag_rd_addr = tag_base + TAG_AW'(way_reg);
    assign tag_wr_en   = (state_reg == S_DONE) && done_go && !hit_found_reg;
    assign tag_wr_addr = tag_base + TAG_AW'(victim);
    assign meta_rd_en  = (state_reg == S_META);
    assign meta_wr_en  = (state_reg == S_DONE) && done_go;

    // next state and datapath
    always_comb
    begin
        set_bits_next    = set_bits_reg;
        offset_bits_next = offset_bits_reg;
        way_count_next   = way_count_reg;
        policy_next      = policy_reg;
        state_next       = state_reg;
        kind_next        = kind_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        ways_next        = ways_reg;
        way_next         = way_reg;
        valid_next       = valid_reg;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            age_next[v] = age_reg[v];
        end
        fifo_next       = fifo_reg;
        hit_found_next  = hit_found_reg;
        hit_way_next    = hit_way_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        best_age_next   = best_age_reg;
        best_way_next   = best_way_reg;
        flags_next      = flags_reg;
        out_valid_next  = out_valid_reg;
        read_cnt_next   = read_cnt_reg;
        write_cnt_next  = write_cnt_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_next    = cfg_data;
                CFG_OFFSET_BITS: offset_bits_next = cfg_data;
                CFG_WAY_COUNT:   way_count_next   = cfg_data;
                CFG_POLICY:      policy_next      = cfg_data[0];
                default:         policy_next      = policy_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next  = kind;
                    set_next   = set_shifted[SET_W-1:0] & set_mask;
                    tag_next   = addr_eff >> tag_shift;
                    ways_next  = eff_ways;
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                valid_next = meta_rd_data[MAX_WAYS-1:0];
                for (int v = 0; v < MAX_WAYS; v++)
                begin
                    age_next[v] = meta_rd_data[MAX_WAYS + v * AGE_W +: AGE_W];
                end
                fifo_next       = meta_rd_data[ROW_W-1 -: WAY_W];
                way_next        = '0;
                hit_found_next  = 1'b0;
                hit_way_next    = '0;
                free_found_next = 1'b0;
                free_way_next   = '0;
                best_age_next   = '0;
                best_way_next   = '0;
                state_next      = S_TRD;
            end
            S_TRD:
            begin
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                if (tag_match)
                begin
                    hit_found_next = 1'b1;
                    hit_way_next   = way_reg;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_way_next   = way_reg;
                end
                if (cur_age > best_age_reg)
                begin
                    best_age_next = cur_age;
                    best_way_next = way_reg;
                end
                if (tag_match || last_way)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    way_next   = way_reg + WAY_W'(1);
                    state_next = S_TRD;
                end
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    flags_next.hit          = hit_found_reg;
                    flags_next.memory_read  = !hit_found_reg;
                    flags_next.memory_write = (kind_reg == KIND_WRITE);
                    out_valid_next          = 1'b1;
                    if (hit_found_reg)
                    begin
                        hit_cnt_next = sat_inc(hit_cnt_reg);
                    end
                    else
                    begin
                        read_cnt_next = sat_inc(read_cnt_reg);
                        miss_cnt_next = sat_inc(miss_cnt_reg);
                    end
                    if (kind_reg == KIND_WRITE)
                    begin
                        write_cnt_next = sat_inc(write_cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            way_count_reg   <= CFG_DATA_W'(1);
            policy_reg      <= POLICY_FIFO;
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            read_cnt_reg    <= '0;
            write_cnt_reg   <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
        end
        else
        begin
            set_bits_reg    <= set_bits_next;
            offset_bits_reg <= offset_bits_next;
            way_count_reg   <= way_count_next;
            policy_reg      <= policy_next;
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            read_cnt_reg    <= read_cnt_next;
            write_cnt_reg   <= write_cnt_next;
            hit_cnt_reg     <= hit_cnt_next;
            miss_cnt_reg    <= miss_cnt_next;
        end
    end

    // access context and result payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        ways_reg       <= ways_next;
        way_reg        <= way_next;
        valid_reg      <= valid_next;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            age_reg[v] <= age_next[v];
        end
        fifo_reg       <= fifo_next;
        hit_found_reg  <= hit_found_next;
        hit_way_reg    <= hit_way_next;
        free_found_reg <= free_found_next;
        free_way_reg   <= free_way_next;
        best_age_reg   <= best_age_next;
        best_way_reg   <= best_way_next;
        flags_reg      <= flags_next;
    end

    // tag store, contents undefined until filled
    sac_ram #(
        .WIDTH (AW),
        .DEPTH (TAG_DEPTH),
        .ADDR_W(TAG_AW)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (tag_wr_en),
        .wr_addr(tag_wr_addr),
        .wr_data(tag_reg),
        .rd_en  (tag_rd_en),
        .rd_addr(tag_rd_addr),
        .rd_data(tag_rd_data)
    );

    // per set valid bits, ages and fifo pointer
    sac_meta_store #(
        .SETS  (MAX_SETS),
        .ROW_W (ROW_W),
        .ADDR_W(SET_W)
    ) u_meta (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (meta_wr_en),
        .wr_addr(set_reg),
        .wr_data(meta_wr_data),
        .rd_en  (meta_rd_en),
        .rd_addr(set_reg),
        .rd_data(meta_rd_data)
    );

    assign hit          = flags_reg.hit;
    assign memory_read  = flags_reg.memory_read;
    assign memory_write = flags_reg.memory_write;
    assign read_total   = read_cnt_reg;
    assign write_total  = write_cnt_reg;
    assign hit_total    = hit_cnt_reg;
    assign miss_total   = miss_cnt_reg;

endmodule

// ===== hw/rtl/sac_checker.sv =====
// port level checks for set_assoc_cache_hit_miss, attached by bind
// depends on sac_pkg
module sac_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                hit,
    input logic                memory_read,
    input logic                memory_write,
    input sac_pkg::count_t     read_total,
    input sac_pkg::count_t     write_total,
    input sac_pkg::count_t     hit_total,
    input sac_pkg::count_t     miss_total
);

    import sac_pkg::*;

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(memory_read)
            && $stable(memory_write) && $stable(read_total) && $stable(write_total)
            && $stable(hit_total) && $stable(miss_total))
    else $error("stalled result changed");

    // each access is either a hit or a fetch, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit != memory_read))
    else $error("hit and memory read disagree");

    // every miss fetches a block, so both totals track each other
    assert property (@(posedge clk) disable iff (!rst_n)
        read_total == miss_total)
    else $error("read and miss totals differ");

    // one access at a time: not ready right after a transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("accepted a second access while busy");

    // hit and write totals only grow
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_total >= $past(hit_total)) && (write_total >= $past(write_total)))
    else $error("running total decreased");

endmodule

bind set_assoc_cache_hit_miss sac_checker u_sac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .memory_read (memory_read),
    .memory_write(memory_write),
    .read_total  (read_total),
    .write_total (write_total),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
);
